[src/ilt_pkg.sv]
`default_nettype none
package ilt_pkg;

    localparam int CAPACITY   = 256;
    localparam int ITEM_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int GRP_SIZE   = 16;
    localparam int NGROUP     = CAPACITY / GRP_SIZE;
    localparam int GRP_W      = $clog2(GRP_SIZE);
    localparam int NGRP_W     = $clog2(NGROUP);

    typedef enum logic [2:0] {
        CMD_APPEND      = 3'd0,
        CMD_INSERT      = 3'd1,
        CMD_REMOVE_LAST = 3'd2,
        CMD_REMOVE_AT   = 3'd3,
        CMD_GET         = 3'd4,
        CMD_FIND_FIRST  = 3'd5,
        CMD_FIND_LAST   = 3'd6,
        CMD_CLEAR       = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GATHER,
        S_COMBINE,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_APPEND,
        OP_INSERT,
        OP_REMOVE
    } t_cell_op;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        t_cell_op              op;
        logic [IDX_W-1:0]      pos;
        logic [IDX_W-1:0]      rd_pos;
        logic [CNT_W-1:0]      count;
        logic [ITEM_WIDTH-1:0] value;
    } t_cell_ctl;

    // Result of the registered reduction over the row.
    typedef struct packed {
        logic                  any;
        logic [IDX_W-1:0]      first;
        logic [IDX_W-1:0]      last;
        logic [ITEM_WIDTH-1:0] value;
    } t_find;

endpackage
`default_nettype wire

[src/ilt_cell.sv]
`default_nettype none
module ilt_cell
    import ilt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic [IDX_W-1:0]      i_index,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [ITEM_WIDTH-1:0] i_below,
    input  wire logic [ITEM_WIDTH-1:0] i_above,
    output logic [ITEM_WIDTH-1:0]      o_entry,
    output logic                       o_hit,
    output logic [ITEM_WIDTH-1:0]      o_pick
);

    logic [ITEM_WIDTH-1:0] r_entry;
    logic [ITEM_WIDTH-1:0] n_entry;
    logic [CNT_W-1:0]      w_index;

    assign w_index = CNT_W'(i_index);

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            OP_APPEND: begin
                if (w_index == i_ctl.count) n_entry = i_ctl.value;
            end
            OP_INSERT: begin
                if (i_index == i_ctl.pos) n_entry = i_ctl.value;
                else if (i_index > i_ctl.pos) n_entry = i_below;
            end
            OP_REMOVE: begin
                if (i_index >= i_ctl.pos) n_entry = i_above;
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // A live entry that equals the search key.
    assign o_hit   = (r_entry == i_ctl.value) && (w_index < i_ctl.count);
    assign o_pick  = (i_index == i_ctl.rd_pos) ? r_entry : '0;
    assign o_entry = r_entry;

endmodule
`default_nettype wire

[src/ilt_reduce.sv]
`default_nettype none
module ilt_reduce
    import ilt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic [CAPACITY-1:0]   i_hit,
    input  wire logic [ITEM_WIDTH-1:0] i_pick [CAPACITY],
    output t_find                      o_find
);

    logic                  r_g_any   [NGROUP];
    logic [GRP_W-1:0]      r_g_first [NGROUP];
    logic [GRP_W-1:0]      r_g_last  [NGROUP];
    logic [ITEM_WIDTH-1:0] r_g_val   [NGROUP];
    logic                  n_g_any   [NGROUP];
    logic [GRP_W-1:0]      n_g_first [NGROUP];
    logic [GRP_W-1:0]      n_g_last  [NGROUP];
    logic [ITEM_WIDTH-1:0] n_g_val   [NGROUP];
    t_find                 r_find;
    t_find                 n_find;

    // First level: priority and OR within each group of cells.
    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            n_g_any[g]   = 1'b0;
            n_g_first[g] = '0;
            n_g_last[g]  = '0;
            n_g_val[g]   = '0;
            for (int k = 0; k < GRP_SIZE; k++) begin
                if (i_hit[g*GRP_SIZE+k]) begin
                    if (!n_g_any[g]) n_g_first[g] = GRP_W'(k);
                    n_g_last[g] = GRP_W'(k);
                    n_g_any[g]  = 1'b1;
                end
                n_g_val[g] = n_g_val[g] | i_pick[g*GRP_SIZE+k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NGROUP; g++) begin
            r_g_any[g]   <= n_g_any[g];
            r_g_first[g] <= n_g_first[g];
            r_g_last[g]  <= n_g_last[g];
            r_g_val[g]   <= n_g_val[g];
        end
    end

    // Second level: the same across the group summaries.
    always_comb begin
        n_find = '0;
        for (int g = 0; g < NGROUP; g++) begin
            if (r_g_any[g]) begin
                if (!n_find.any) n_find.first = {NGRP_W'(g), r_g_first[g]};
                n_find.last = {NGRP_W'(g), r_g_last[g]};
                n_find.any  = 1'b1;
            end
            n_find.value = n_find.value | r_g_val[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_find <= n_find;
    end

    assign o_find = r_find;

endmodule
`default_nettype wire

[src/indexed_list_table.sv]
`default_nettype none
// Ordered list of up to CAPACITY values held in a row of cells.
//
// Commands arrive as a transaction on start with cmd, item_value and position;
// a transaction is taken at a clock edge where start is high and busy is low.
// Every command produces exactly one result, shown for one cycle with o_done:
// the value read or removed, the position found by a search, a status code and
// the fill count after the command. The receiver cannot stall the block.
//
// A command is latched and then passes through the states gather, combine
// and done: in gather and combine the registered two-level reduction picks
// the addressed entry and the first and last matching entries across the row,
// and in done the cells shift or write and the result is registered. o_done
// rises in the same cycle in which busy falls, and a new command may be
// accepted in that cycle, not earlier. The reduction depth sets its length.
//
// Reset clears the fill count and the control state; the stored values are
// not cleared and are never read before they are written.
module indexed_list_table
    import ilt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [31:0] i_item_value,
    input  wire logic [7:0]  i_position,
    output logic             busy,
    output logic             o_done,
    output logic [31:0]      o_result_value,
    output logic [7:0]       o_result_position,
    output logic [2:0]       o_status,
    output logic [8:0]       o_entry_count
);

    t_state                r_state;
    t_state                n_state;
    t_cmd                  r_cmd;
    logic [ITEM_WIDTH-1:0] r_value;
    logic [IDX_W-1:0]      r_pos;
    logic [IDX_W-1:0]      r_rd_pos;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_done;
    logic [ITEM_WIDTH-1:0] r_res_value;
    logic [ITEM_WIDTH-1:0] n_res_value;
    logic [IDX_W-1:0]      r_res_pos;
    logic [IDX_W-1:0]      n_res_pos;
    t_status               r_res_status;
    t_status               n_res_status;
    t_cell_op              n_op;
    t_cell_ctl             w_ctl;
    t_find                 w_find;
    logic                  w_accept;
    logic                  w_pos_bad;
    logic                  w_full;

    logic [ITEM_WIDTH-1:0] w_entry [CAPACITY];
    logic [ITEM_WIDTH-1:0] w_pick  [CAPACITY];
    logic [CAPACITY-1:0]   w_hit;

    assign w_accept  = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign w_pos_bad = (CNT_W'(r_pos) >= r_count);
    assign w_full    = (r_count >= CNT_W'(CAPACITY));

    // Command registers. For remove last, the addressed entry is the top one.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_value <= ITEM_WIDTH'(i_item_value);
            r_pos   <= i_position;
            if (t_cmd'(i_cmd) == CMD_REMOVE_LAST) begin
                r_rd_pos <= r_count[IDX_W-1:0] - IDX_W'(1);
            end else begin
                r_rd_pos <= i_position;
            end
        end
    end

    // Next state.
    always_comb begin
        case (r_state)
            S_IDLE:    n_state = w_accept ? S_GATHER : S_IDLE;
            S_GATHER:  n_state = S_COMBINE;
            S_COMBINE: n_state = S_DONE;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Outputs of the final step: status, result fields, cell operation.
    always_comb begin
        n_op         = OP_HOLD;
        n_count      = r_count;
        n_res_value  = '0;
        n_res_pos    = '0;
        n_res_status = ST_OK;
        if (r_state == S_DONE) begin
            case (r_cmd)
                CMD_APPEND: begin
                    if (w_full) begin
                        n_res_status = ST_FULL;
                    end else begin
                        n_op    = OP_APPEND;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                CMD_INSERT: begin
                    if (w_pos_bad) begin
                        n_res_status = ST_RANGE;
                    end else if (w_full) begin
                        n_res_status = ST_FULL;
                    end else begin
                        n_op    = OP_INSERT;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                CMD_REMOVE_LAST: begin
                    if (r_count == '0) begin
                        n_res_status = ST_EMPTY;
                    end else begin
                        n_res_value = w_find.value;
                        n_count     = r_count - CNT_W'(1);
                    end
                end
                CMD_REMOVE_AT: begin
                    if (w_pos_bad) begin
                        n_res_status = ST_RANGE;
                    end else begin
                        n_res_value = w_find.value;
                        n_op        = OP_REMOVE;
                        n_count     = r_count - CNT_W'(1);
                    end
                end
                CMD_GET: begin
                    if (w_pos_bad) n_res_status = ST_RANGE;
                    else n_res_value = w_find.value;
                end
                CMD_FIND_FIRST: begin
                    if (w_find.any) n_res_pos = w_find.first;
                    else n_res_status = ST_NOTFOUND;
                end
                CMD_FIND_LAST: begin
                    if (w_find.any) n_res_pos = w_find.last;
                    else n_res_status = ST_NOTFOUND;
                end
                CMD_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= (r_state == S_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            r_res_value  <= n_res_value;
            r_res_pos    <= n_res_pos;
            r_res_status <= n_res_status;
        end
    end

    // Broadcast to the row. The count seen by the cells is the one before
    // the command, which is where an append writes.
    assign w_ctl.op     = n_op;
    assign w_ctl.pos    = r_pos;
    assign w_ctl.rd_pos = r_rd_pos;
    assign w_ctl.count  = r_count;
    assign w_ctl.value  = r_value;

    // The row of cells; each one takes from its lower neighbor on insert and
    // from its upper neighbor on removal.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [ITEM_WIDTH-1:0] w_below;
        logic [ITEM_WIDTH-1:0] w_above;
        if (i == 0) begin : g_bottom
            assign w_below = '0;
        end else begin : g_mid_b
            assign w_below = w_entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_top
            assign w_above = w_entry[i];
        end else begin : g_mid_a
            assign w_above = w_entry[i+1];
        end
        ilt_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(i)),
            .i_ctl   (w_ctl),
            .i_below (w_below),
            .i_above (w_above),
            .o_entry (w_entry[i]),
            .o_hit   (w_hit[i]),
            .o_pick  (w_pick[i])
        );
    end

    ilt_reduce u_reduce (
        .i_clk  (i_clk),
        .i_hit  (w_hit),
        .i_pick (w_pick),
        .o_find (w_find)
    );

    assign o_done            = r_done;
    assign o_result_value    = 32'(r_res_value);
    assign o_result_position = r_res_pos;
    assign o_status          = r_res_status;
    assign o_entry_count     = r_count;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count exceeds capacity");

    // A result follows only the final step of a command.
    a_done_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_DONE))
        else $error("result without a finished command");

    // An accepted command keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted command did not start");

    // Full is reported only when the list is at capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_FULL)) |-> (o_entry_count == CNT_W'(CAPACITY)))
        else $error("full status with room left");

endmodule
`default_nettype wire
